FILE: src/uesd_pkg.sv
// ---------------------------------------------------------------------------
// uesd_pkg: shared types and constants for the edge sort/dedup unit
// Edge storage format, channel field widths, sort key helper, FSM states.
// ---------------------------------------------------------------------------
package uesd_pkg;

   // Store geometry and vertex width inside the store
   localparam int MAX_EDGES   = 64;
   localparam int VERTEX_BITS = 16;
   // Width of vertex fields on the channels
   localparam int FIELD_BITS  = 16;

   localparam int IDX_BITS = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CNT_BITS = $clog2(MAX_EDGES + 1);

   // Request commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   typedef logic [VERTEX_BITS-1:0]   vertex_type;
   typedef logic [2*VERTEX_BITS-1:0] key_type;

   typedef struct packed {
      vertex_type a;
      vertex_type b;
   } edge_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_COMPARE,
      ST_EMIT
   } state_type;

   // Orientation-free sort key: smaller endpoint, then larger endpoint
   function automatic key_type edge_key(input edge_type e);
      key_type k;
      if (e.a < e.b) begin
         k = {e.a, e.b};
      end else begin
         k = {e.b, e.a};
      end
      return k;
   endfunction

endpackage

FILE: src/uesd_if.sv
// ---------------------------------------------------------------------------
// uesd_if: request and response channels of the edge sort/dedup unit
// Valid/ready channels; a transfer happens when valid and ready are high.
// ---------------------------------------------------------------------------
interface uesd_req_if import uesd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [FIELD_BITS-1:0] first_vertex;
   logic [FIELD_BITS-1:0] second_vertex;

   modport source (output valid, output cmd, output first_vertex,
                   output second_vertex, input ready);
   modport sink   (input valid, input cmd, input first_vertex,
                   input second_vertex, output ready);
endinterface

interface uesd_rsp_if import uesd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] edge_first;
   logic [FIELD_BITS-1:0] edge_second;
   logic                  is_last;
   logic                  is_empty;
   logic                  overflowed;

   modport source (output valid, output edge_first, output edge_second,
                   output is_last, output is_empty, output overflowed,
                   input ready);
   modport sink   (input valid, input edge_first, input edge_second,
                   input is_last, input is_empty, input overflowed,
                   output ready);
endinterface

FILE: src/undirected_edge_sort_dedup_unit.sv
// ---------------------------------------------------------------------------
// undirected_edge_sort_dedup_unit: sorts stored undirected edges, drops dups
//
// Requests arrive on req_ch. A load request (cmd 0) writes one edge into the
// 64-entry edge store; loads past capacity are dropped and
// set the overflow flag. A run request (cmd 1) emits on rsp_ch every unique
// edge, ascending by smaller then larger endpoint, the earliest-loaded copy
// of each duplicate group in its stored orientation; the last one carries
// is_last. An empty store gives one result with is_empty and is_last set.
// The run ends by clearing the store and the overflow flag.
// A run is a selection sort on one shared compare unit: each result costs a
// full pass over the N stored edges (memory read, then compare, per edge).
// req_ch.ready stays low from a run request until the run ends; the last
// result shows in the cycle ready returns. Results sit in an output
// register; when the receiver stalls the next result waits in the
// sequencer and the scan pauses. Synchronous reset empties the store and
// clears the state, the overflow flag and the output valid flag.
// ---------------------------------------------------------------------------
module undirected_edge_sort_dedup_unit import uesd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   uesd_req_if.sink      req_ch,
   uesd_rsp_if.source    rsp_ch
);

   state_type state_ff, state_in;

   logic [CNT_BITS-1:0] cnt_ff;
   logic                ovf_ff;
   edge_type            mem [MAX_EDGES];
   edge_type            rd_data_ff;

   logic [IDX_BITS-1:0] idx_ff;
   edge_type            best_ff;
   key_type             best_key_ff;
   logic                found_ff;
   key_type             last_key_ff;
   logic                have_last_ff;
   edge_type            pend_ff;
   logic                pend_valid_ff;
   logic                last_flag_ff;
   logic                empty_ff;

   logic                out_valid_ff;
   edge_type            out_edge_ff;
   logic                out_last_ff;
   logic                out_empty_ff;
   logic                out_ovf_ff;

   logic    req_accept, load_go, run_go, out_free, pass_end;
   logic    rd_en, take, found_next;
   key_type rd_key;
   edge_type best_next;
   key_type  best_key_next;
   edge_type load_edge;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign load_go    = req_accept && (req_ch.cmd == CMD_LOAD);
   assign run_go     = req_accept && (req_ch.cmd == CMD_RUN);
   assign out_free   = !out_valid_ff || rsp_ch.ready;
   assign pass_end   = (CNT_BITS'(idx_ff) + CNT_BITS'(1)) == cnt_ff;

   assign load_edge.a = vertex_type'(req_ch.first_vertex);
   assign load_edge.b = vertex_type'(req_ch.second_vertex);

   // Shared compare unit: above last selected key and below current best
   always_comb begin
      rd_key        = edge_key(rd_data_ff);
      take          = (!have_last_ff || (rd_key > last_key_ff)) &&
                      (!found_ff || (rd_key < best_key_ff));
      found_next    = found_ff || take;
      best_next     = take ? rd_data_ff : best_ff;
      best_key_next = take ? rd_key : best_key_ff;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (run_go) begin
               state_in = (cnt_ff == '0) ? ST_EMIT : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (pass_end && pend_valid_ff) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = last_flag_ff ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_ch.ready = 1'b0;
      rd_en        = 1'b0;
      case (state_ff)
         ST_IDLE:    req_ch.ready = 1'b1;
         ST_READ:    rd_en = 1'b1;
         ST_COMPARE: rd_en = 1'b0;
         ST_EMIT:    rd_en = 1'b0;
         default:    req_ch.ready = 1'b0;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_go) begin
            if (cnt_ff < CNT_BITS'(MAX_EDGES)) begin
               cnt_ff <= cnt_ff + CNT_BITS'(1);
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (state_ff == ST_EMIT && out_free) begin
            out_valid_ff <= 1'b1;
            if (last_flag_ff) begin
               cnt_ff <= '0;
               ovf_ff <= 1'b0;
            end
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Edge store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (load_go && (cnt_ff < CNT_BITS'(MAX_EDGES))) begin
         mem[cnt_ff[IDX_BITS-1:0]] <= load_edge;
      end
      if (rd_en) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   // Scan and result datapath
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && run_go) begin
         idx_ff        <= '0;
         found_ff      <= 1'b0;
         have_last_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_ff       <= '0;
         empty_ff      <= (cnt_ff == '0);
         last_flag_ff  <= (cnt_ff == '0);
      end
      if (state_ff == ST_COMPARE) begin
         best_ff     <= best_next;
         best_key_ff <= best_key_next;
         if (pass_end) begin
            idx_ff <= '0;
            if (pend_valid_ff) begin
               found_ff     <= found_next;
               last_flag_ff <= !found_next;
            end else begin
               // first pass: the smallest edge becomes the pending result
               pend_ff       <= best_next;
               pend_valid_ff <= 1'b1;
               last_key_ff   <= best_key_next;
               have_last_ff  <= 1'b1;
               found_ff      <= 1'b0;
            end
         end else begin
            found_ff <= found_next;
            idx_ff   <= idx_ff + IDX_BITS'(1);
         end
      end
      if (state_ff == ST_EMIT && out_free) begin
         out_edge_ff  <= pend_ff;
         out_last_ff  <= last_flag_ff;
         out_empty_ff <= empty_ff;
         out_ovf_ff   <= ovf_ff;
         // next pending result is the best of the pass just ended
         pend_ff      <= best_ff;
         last_key_ff  <= best_key_ff;
         found_ff     <= 1'b0;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.edge_first  = FIELD_BITS'(out_edge_ff.a);
   assign rsp_ch.edge_second = FIELD_BITS'(out_edge_ff.b);
   assign rsp_ch.is_last     = out_last_ff;
   assign rsp_ch.is_empty    = out_empty_ff;
   assign rsp_ch.overflowed  = out_ovf_ff;

   // Checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(MAX_EDGES))
      else $error("edge count above capacity");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (CNT_BITS'(idx_ff) < cnt_ff))
      else $error("scan index beyond stored edges");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && !last_flag_ff) |->
         (have_last_ff && found_ff && (best_key_ff > last_key_ff)))
      else $error("next result does not ascend");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_empty_ff) |->
         (out_last_ff && out_edge_ff == '0))
      else $error("empty result malformed");

   a_run_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (!req_ch.ready && $stable(cnt_ff)))
      else $error("request taken during run");

endmodule
